[sv/pcl_pkg.sv]
// Package for the polygon plane clipper: constants, vertex and job types,
// and the back-end state encoding. No dependencies.
package pcl_pkg;

   localparam int MaxVerts = 40;
   localparam int PosW     = 7;
   localparam int CoordW   = 32;

   typedef logic signed [CoordW-1:0] coord_type;
   // Element 0 is depth, 1 offset, 2 world x, 3 world y.
   typedef coord_type [3:0] vert_type;

   typedef struct packed {
      vert_type   va;     // previous vertex
      vert_type   vb;     // current vertex
      vert_type   vc;     // first vertex of the polygon
      logic [1:0] kind;
      coord_type  plane;
      logic       do_e1;  // edge previous -> current
      logic       do_e2;  // closing edge current -> first
      logic       last;
   } job_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_SIDE,
      B_PLAN,
      B_SLOT,
      B_NORM,
      B_DIV,
      B_MUL,
      B_ADD,
      B_EMIT,
      B_END
   } back_state_type;

endpackage

[sv/pcl_queue.sv]
// Two-entry job queue between the clipper front end and back end.
// Depends on pcl_pkg for the job type.
module pcl_queue
   import pcl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    full,
   output logic    empty
);

   job_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

[sv/pcl_front.sv]
// Clipper front end: accepts vertex transactions, tracks the polygon position,
// keeps the first and previous vertex and queues one job per vertex.
// Depends on pcl_pkg.
module pcl_front
   import pcl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  coord_type   req_vert_depth,
   input  coord_type   req_vert_offset,
   input  coord_type   req_vert_world_x,
   input  coord_type   req_vert_world_y,
   input  logic [1:0]  req_plane_kind,
   input  coord_type   req_plane_value,
   input  logic [5:0]  req_vertex_count,
   input  logic        q_full,
   output logic        push,
   output job_type     push_job
);

   vert_type   first_ff;
   vert_type   prev_ff;
   logic [5:0] pos_ff;

   vert_type   cur;
   logic [5:0] neff;
   logic       last;
   logic       big;
   logic       started;

   assign req_ready = ~q_full;
   assign push      = req_valid & ~q_full;

   always_comb begin
      cur     = {req_vert_world_y, req_vert_world_x, req_vert_offset, req_vert_depth};
      neff    = (req_vertex_count == 6'd0) ? 6'd1 : req_vertex_count;
      last    = ({1'b0, pos_ff} + 7'd1) >= {1'b0, neff};
      big     = req_vertex_count >= 6'd3;
      started = pos_ff != 6'd0;

      push_job       = '0;
      push_job.va    = prev_ff;
      push_job.vb    = cur;
      push_job.vc    = first_ff;
      push_job.kind  = req_plane_kind;
      push_job.plane = req_plane_value;
      push_job.do_e1 = started & big;
      push_job.do_e2 = started & big & last;
      push_job.last  = last;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         prev_ff <= cur;
         if (!started) begin
            first_ff <= cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 6'd0;
      end else if (push) begin
         pos_ff <= last ? 6'd0 : pos_ff + 6'd1;
      end
   end

endmodule

[sv/pcl_back.sv]
// Clipper back end: computes plane sides, plans the emitted vertices, divides
// and interpolates crossings, and drives the registered result channel.
// Depends on pcl_pkg.
module pcl_back
   import pcl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  job_type     head_job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output coord_type   rsp_out_depth,
   output coord_type   rsp_out_offset,
   output coord_type   rsp_out_world_x,
   output coord_type   rsp_out_world_y,
   output logic        rsp_out_valid,
   output logic [5:0]  rsp_out_index,
   output logic        rsp_dropped_flag,
   output logic        rsp_poly_last
);

   back_state_type state_ff, state_in;

   vert_type          va_ff, vb_ff, vc_ff;
   logic [1:0]        kind_ff;
   coord_type         plane_ff;
   logic              do1_ff, do2_ff, last_ff;
   logic [1:0]        k_ff;
   logic signed [63:0] prod_ff;
   coord_type         pd_ff, po_ff;
   logic signed [63:0] s0_ff, s1_ff, s2_ff;
   logic [3:0]        plan_ff;
   logic              drop_a_ff, drop_b_ff, none_ff;
   logic [1:0]        lastslot_ff;
   logic [2:0]        slot_ff;
   logic [63:0]       num_ff, den_ff;
   logic [31:0]       rem_ff;
   logic [32:0]       q_ff;
   logic [5:0]        dcnt_ff;
   logic [1:0]        fj_ff;
   logic [63:0]       bprod_ff;
   vert_type          xr_ff;
   logic [PosW-1:0]   pos_ff;
   logic              drop_ff;

   vert_type          rsp_vert_ff;
   logic              rsp_valid_ff, rsp_out_valid_ff, rsp_drop_ff, rsp_last_ff;
   logic [5:0]        rsp_index_ff;

   logic              out_free;
   logic              load_out;
   logic              marker;
   logic              is_final;

   // Side computation and plan.
   vert_type          vk;
   logic signed [63:0] side_new;
   logic              nn0, nn1, ps0, ps1, ps2;
   logic              v1, c1, v2, c2, dr1, dr2;
   logic [PosW-1:0]   p1, p2, p3;

   // Edge datapath.
   vert_type          ea, eb;
   logic signed [63:0] sa, sb;
   logic [63:0]       mag_a, mag_b;
   coord_type         aj, bj;
   logic              b_ge_a;
   logic [31:0]       dmag;
   logic [63:0]       rounded;
   coord_type         blend_res;
   logic [32:0]       r2;
   logic              sub_ok;

   function automatic logic room(input logic [PosW-1:0] p);
      return p < PosW'(MaxVerts);
   endfunction

   always_comb begin
      out_free = ~rsp_valid_ff | rsp_ready;

      unique case (k_ff)
         2'd0:    vk = va_ff;
         2'd1:    vk = vb_ff;
         default: vk = vc_ff;
      endcase

      unique case (kind_ff)
         2'd0: side_new = (64'(pd_ff) - 64'(plane_ff)) <<< 16;
         2'd1: side_new = (64'(plane_ff) - 64'(pd_ff)) <<< 16;
         2'd2: side_new = prod_ff - (64'(po_ff) <<< 16);
         default: side_new = prod_ff + (64'(po_ff) <<< 16);
      endcase

      nn0 = ~s0_ff[63];
      nn1 = ~s1_ff[63];
      ps0 = nn0 & (s0_ff != 64'sd0);
      ps1 = nn1 & (s1_ff != 64'sd0);
      ps2 = ~s2_ff[63] & (s2_ff != 64'sd0);

      v1  = do1_ff & nn0 & room(pos_ff);
      dr1 = do1_ff & nn0 & ~room(pos_ff);
      p1  = pos_ff + PosW'(v1);
      c1  = do1_ff & (ps0 != ps1) & room(p1);
      p2  = p1 + PosW'(c1);
      v2  = do2_ff & nn1 & room(p2);
      dr2 = do2_ff & nn1 & ~room(p2);
      p3  = p2 + PosW'(v2);
      c2  = do2_ff & (ps1 != ps2) & room(p3);

      ea = slot_ff[1] ? vb_ff : va_ff;
      eb = slot_ff[1] ? vc_ff : vb_ff;
      sa = slot_ff[1] ? s1_ff : s0_ff;
      sb = slot_ff[1] ? s2_ff : s1_ff;
      mag_a = sa[63] ? 64'(-sa) : 64'(sa);
      mag_b = sb[63] ? 64'(-sb) : 64'(sb);

      aj        = ea[fj_ff];
      bj        = eb[fj_ff];
      b_ge_a    = bj >= aj;
      dmag      = b_ge_a ? 32'(33'(bj) - 33'(aj)) : 32'(33'(aj) - 33'(bj));
      rounded   = bprod_ff + 64'h0000_0000_8000_0000;
      blend_res = b_ge_a ? aj + coord_type'(rounded[63:32])
                         : aj - coord_type'(rounded[63:32]);

      r2     = {rem_ff, num_ff[63]};
      sub_ok = r2 >= {1'b0, den_ff[31:0]};

      // The final result of a polygon carries the drop bit of the whole item.
      is_final = last_ff & (slot_ff[1:0] == lastslot_ff);
   end

   // Next state and handshake outputs.
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      load_out = 1'b0;
      marker   = last_ff & none_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               state_in = B_SIDE;
            end
         end
         B_SIDE: begin
            if (k_ff == 2'd3) begin
               state_in = B_PLAN;
            end
         end
         B_PLAN: state_in = B_SLOT;
         B_SLOT: begin
            priority if (slot_ff[2]) begin
               state_in = B_END;
            end else if (!plan_ff[slot_ff[1:0]]) begin
               state_in = B_SLOT;
            end else if (!slot_ff[0]) begin
               state_in = B_EMIT;
            end else begin
               state_in = B_NORM;
            end
         end
         B_NORM: begin
            if (den_ff[63:32] == 32'd0) begin
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            if (dcnt_ff == 6'd63) begin
               state_in = B_MUL;
            end
         end
         B_MUL: state_in = B_ADD;
         B_ADD: begin
            if (fj_ff == 2'd3) begin
               state_in = B_EMIT;
            end else begin
               state_in = B_MUL;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = B_SLOT;
            end
         end
         B_END: begin
            if (!marker) begin
               state_in = B_IDLE;
            end else if (out_free) begin
               load_out = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            if (pop) begin
               va_ff    <= head_job.va;
               vb_ff    <= head_job.vb;
               vc_ff    <= head_job.vc;
               kind_ff  <= head_job.kind;
               plane_ff <= head_job.plane;
               do1_ff   <= head_job.do_e1;
               do2_ff   <= head_job.do_e2;
               last_ff  <= head_job.last;
               k_ff     <= 2'd0;
            end
         end
         B_SIDE: begin
            // Multiply for vertex k while the side of vertex k-1 is formed.
            prod_ff <= 64'(vk[0]) * 64'(plane_ff);
            pd_ff   <= vk[0];
            po_ff   <= vk[1];
            unique case (k_ff)
               2'd1:    s0_ff <= side_new;
               2'd2:    s1_ff <= side_new;
               2'd3:    s2_ff <= side_new;
               default: s0_ff <= s0_ff;
            endcase
            k_ff <= k_ff + 2'd1;
         end
         B_PLAN: begin
            plan_ff   <= {c2, v2, c1, v1};
            drop_a_ff <= drop_ff | dr1;
            drop_b_ff <= drop_ff | dr1 | dr2;
            none_ff   <= ~(c2 | v2 | c1 | v1);
            priority if (c2) begin
               lastslot_ff <= 2'd3;
            end else if (v2) begin
               lastslot_ff <= 2'd2;
            end else if (c1) begin
               lastslot_ff <= 2'd1;
            end else begin
               lastslot_ff <= 2'd0;
            end
            slot_ff <= 3'd0;
         end
         B_SLOT: begin
            if (!slot_ff[2]) begin
               priority if (!plan_ff[slot_ff[1:0]]) begin
                  slot_ff <= slot_ff + 3'd1;
               end else if (!slot_ff[0]) begin
                  xr_ff <= ea;
               end else begin
                  num_ff <= mag_a;
                  den_ff <= mag_a + mag_b;
               end
            end
         end
         B_NORM: begin
            if (den_ff[63:32] != 32'd0) begin
               num_ff <= num_ff >> 1;
               den_ff <= den_ff >> 1;
            end else begin
               num_ff  <= {num_ff[31:0], 32'd0};
               rem_ff  <= 32'd0;
               q_ff    <= 33'd0;
               dcnt_ff <= 6'd0;
               fj_ff   <= 2'd0;
            end
         end
         B_DIV: begin
            // Restoring division, one quotient bit per cycle.
            rem_ff  <= sub_ok ? 32'(r2 - {1'b0, den_ff[31:0]}) : r2[31:0];
            q_ff    <= {q_ff[31:0], sub_ok};
            num_ff  <= num_ff << 1;
            dcnt_ff <= dcnt_ff + 6'd1;
         end
         B_MUL: begin
            bprod_ff <= 64'(dmag) * 64'(q_ff);
         end
         B_ADD: begin
            xr_ff[fj_ff] <= blend_res;
            fj_ff        <= fj_ff + 2'd1;
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_vert_ff      <= xr_ff;
               rsp_out_valid_ff <= 1'b1;
               rsp_index_ff     <= 6'(pos_ff + PosW'(1));
               rsp_drop_ff      <= (slot_ff[1] | is_final) ? drop_b_ff : drop_a_ff;
               rsp_last_ff      <= is_final;
               slot_ff          <= slot_ff + 3'd1;
            end
         end
         B_END: begin
            if (marker && out_free) begin
               rsp_vert_ff      <= '0;
               rsp_out_valid_ff <= 1'b0;
               rsp_index_ff     <= 6'(pos_ff);
               rsp_drop_ff      <= drop_b_ff;
               rsp_last_ff      <= 1'b1;
            end
         end
         default: k_ff <= k_ff;
      endcase
   end

   // Control state: running output count, sticky drop bit, output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == B_EMIT && out_free) begin
            pos_ff <= pos_ff + PosW'(1);
         end
         if (state_ff == B_END && state_in == B_IDLE) begin
            if (last_ff) begin
               pos_ff  <= '0;
               drop_ff <= 1'b0;
            end else begin
               drop_ff <= drop_b_ff;
            end
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_depth    = rsp_vert_ff[0];
   assign rsp_out_offset   = rsp_vert_ff[1];
   assign rsp_out_world_x  = rsp_vert_ff[2];
   assign rsp_out_world_y  = rsp_vert_ff[3];
   assign rsp_out_valid    = rsp_out_valid_ff;
   assign rsp_out_index    = rsp_index_ff;
   assign rsp_dropped_flag = rsp_drop_ff;
   assign rsp_poly_last    = rsp_last_ff;

endmodule

[sv/polygon_plane_clipper.sv]
// Polygon plane clipper top level: front end, job queue and back end.
// Per vertex the back end forms the plane sides, plans the outputs and emits each
// kept vertex; each crossing is normalized, divided serially and interpolated.
// The queue lets the front end take new vertices while the back end works on a job.
// Synchronous active-high reset clears positions, drop bit, queue and output valid.
// Depends on pcl_pkg, pcl_front, pcl_queue and pcl_back.
module polygon_plane_clipper
   import pcl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  coord_type   req_vert_depth,
   input  coord_type   req_vert_offset,
   input  coord_type   req_vert_world_x,
   input  coord_type   req_vert_world_y,
   input  logic [1:0]  req_plane_kind,
   input  coord_type   req_plane_value,
   input  logic [5:0]  req_vertex_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output coord_type   rsp_out_depth,
   output coord_type   rsp_out_offset,
   output coord_type   rsp_out_world_x,
   output coord_type   rsp_out_world_y,
   output logic        rsp_out_valid,
   output logic [5:0]  rsp_out_index,
   output logic        rsp_dropped_flag,
   output logic        rsp_poly_last
);

   logic    push, pop, q_full, q_empty;
   job_type push_job, head_job;

   pcl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_vert_depth   (req_vert_depth),
      .req_vert_offset  (req_vert_offset),
      .req_vert_world_x (req_vert_world_x),
      .req_vert_world_y (req_vert_world_y),
      .req_plane_kind   (req_plane_kind),
      .req_plane_value  (req_plane_value),
      .req_vertex_count (req_vertex_count),
      .q_full           (q_full),
      .push             (push),
      .push_job         (push_job)
   );

   pcl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   pcl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_depth    (rsp_out_depth),
      .rsp_out_offset   (rsp_out_offset),
      .rsp_out_world_x  (rsp_out_world_x),
      .rsp_out_world_y  (rsp_out_world_y),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_index    (rsp_out_index),
      .rsp_dropped_flag (rsp_dropped_flag),
      .rsp_poly_last    (rsp_poly_last)
   );

   // An end marker always closes its polygon.
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_poly_last)
      else $error("end marker without poly_last");

   // An end marker carries zero coordinates.
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_depth == 0 && rsp_out_world_x == 0)
      else $error("end marker with nonzero vertex");

   // Emitted vertices are counted from one up to the cap.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |->
         rsp_out_index != 6'd0 && {1'b0, rsp_out_index} <= 7'(MaxVerts))
      else $error("vertex index out of range");

endmodule
